// ===== rtl/aes128_block_encrypt_defines.svh =====
// Assertion macros used by the checker file.
`ifndef AES128_BLOCK_ENCRYPT_DEFINES_SVH
`define AES128_BLOCK_ENCRYPT_DEFINES_SVH

// Check that a property holds at every clock edge outside reset.
`define AES_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every clock edge, reset included.
`define AES_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/aes_pkg.sv =====
package aes_pkg;

    localparam int unsigned KeyW   = 64;
    localparam int unsigned BlockW = 128;
    localparam int unsigned NumRounds = 10;
    localparam int unsigned NumWords = 44;
    localparam int unsigned FullRounds = 9;
    localparam logic [7:0] ByteMask = 8'h0ff;

    // Configuration register indexes.
    localparam logic CfgKeyHigh = 1'b0;
    localparam logic CfgKeyLow  = 1'b1;

    typedef logic [127:0] t_block;

    // Forward S-box.
    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // Round constants for rounds 1 to 10.
    localparam logic [7:0] RCON [NumRounds] = '{
        8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // Next four round-key words from the current four.
    function automatic t_block next_key(input t_block k, input logic [7:0] rc);
        logic [31:0] t;
        logic [31:0] w0, w1, w2, w3;
        t = {SBOX[k[23:16]], SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]} ^ {rc, 24'h0};
        w0 = k[127:96] ^ t;
        w1 = k[95:64] ^ w0;
        w2 = k[63:32] ^ w1;
        w3 = k[31:0] ^ w2;
        next_key = {w0, w1, w2, w3};
    endfunction

    // One cipher round: SubBytes, ShiftRows, optional MixColumns, AddRoundKey.
    function automatic t_block round_fn(input t_block s, input t_block k, input logic mix);
        logic [7:0] b [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3;
        t_block o;
        for (int i = 0; i < 16; i++) begin
            b[i] = SBOX[s[127 - 8 * i -: 8]];
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[r + 4 * c] = b[r + 4 * ((c + r) % 4)];
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0 = t[4 * c]; a1 = t[4 * c + 1]; a2 = t[4 * c + 2]; a3 = t[4 * c + 3];
            if (mix) begin
                t[4 * c]     = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
                t[4 * c + 1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
                t[4 * c + 2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
                t[4 * c + 3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
            end
        end
        for (int i = 0; i < 16; i++) begin
            o[127 - 8 * i -: 8] = t[i] ^ k[127 - 8 * i -: 8];
        end
        round_fn = o;
    endfunction

endpackage

// ===== rtl/aes_stream_if.sv =====
interface aes_stream_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_high;
    logic [63:0] data_low;

    modport source (output valid, output data_high, output data_low, input ready);
    modport sink   (input valid, input data_high, input data_low, output ready);
endinterface

// ===== rtl/aes128_block_encrypt.sv =====
// Channel   | Direction | Payload
// s_in      | sink      | plaintext_high (data_high), plaintext_low (data_low)
// m_out     | source    | ciphertext_high (data_high), ciphertext_low (data_low)
// config    | write     | i_cfg_index 0 = key_high, 1 = key_low
// One block enters per cycle unless the output stalls. The pipeline has an initial AddRoundKey
// stage and one register stage per round, each round stage also expanding its round key.
// Each stage carries its own key copy, so key writes affect only later blocks.
// A stall at the output freezes the whole pipeline; valid bits travel per stage.
// Reset (synchronous, active low) clears the valid bits and the key registers.
module aes128_block_encrypt (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_index,
    input  logic [63:0]   i_cfg_data,
    aes_stream_if.sink    s_in,
    aes_stream_if.source  m_out
);
    import aes_pkg::*;

    logic [KeyW-1:0] r_key_high, r_key_low;
    logic            r_valid [NumRounds + 1];
    t_block          r_state [NumRounds + 1];
    t_block          r_rkey  [NumRounds + 1];
    logic            w_adv;

    // Key registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CfgKeyHigh: r_key_high <= i_cfg_data;
                CfgKeyLow:  r_key_low  <= i_cfg_data;
                default:    r_key_high <= r_key_high;
            endcase
        end
    end

    // Pipeline moves when the last stage is empty or taken.
    assign w_adv      = !r_valid[NumRounds] || m_out.ready;
    assign s_in.ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= NumRounds; i++) r_valid[i] <= 1'b0;
        end else if (w_adv) begin
            r_valid[0] <= s_in.valid;
            for (int i = 1; i <= NumRounds; i++) r_valid[i] <= r_valid[i - 1];
        end
    end

    // Stage 0 does the initial AddRoundKey; stage i does round i.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_state[0] <= {s_in.data_high, s_in.data_low} ^ {r_key_high, r_key_low};
            r_rkey[0]  <= {r_key_high, r_key_low};
            for (int i = 1; i <= NumRounds; i++) begin
                r_rkey[i]  <= next_key(r_rkey[i - 1], RCON[i - 1]);
                r_state[i] <= round_fn(r_state[i - 1], next_key(r_rkey[i - 1], RCON[i - 1]),
                                       (i <= FullRounds));
            end
        end
    end

    assign m_out.valid     = r_valid[NumRounds];
    assign m_out.data_high = r_state[NumRounds][127:64];
    assign m_out.data_low  = r_state[NumRounds][63:0];
endmodule

// ===== rtl/aes128_block_encrypt_checker.sv =====
`include "aes128_block_encrypt_defines.svh"

module aes128_block_encrypt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] out_high
);
    // A stalled result holds.
    `AES_ASSERT_CLK(a_hold, i_clk, i_rst_n, out_valid && !out_ready |=> out_valid && $stable(out_high), "result dropped under stall")
    // Input is refused only while the output stalls.
    `AES_ASSERT_CLK(a_ready, i_clk, i_rst_n, !in_ready |-> out_valid && !out_ready, "input refused without stall")
    // An offered input block stays offered until it is taken.
    `AES_ASSERT_CLK(a_in_hold, i_clk, i_rst_n, in_valid && !in_ready |=> in_valid, "input withdrawn before transaction")
    // Nothing comes out right after reset.
    `AES_ASSERT_ALWAYS(a_rst, i_clk, !i_rst_n |=> !out_valid, "output valid after reset")
endmodule

bind aes128_block_encrypt aes128_block_encrypt_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(s_in.valid), .in_ready(s_in.ready),
    .out_valid(m_out.valid), .out_ready(m_out.ready), .out_high(m_out.data_high)
);
